// ===== hw/rtl/sdq_pkg.sv =====
`timescale 1ns / 1ps

package sdq_pkg;

    // default sizes
    localparam int CHANNELS_DEFAULT   = 1024;
    localparam int POWER_BITS_DEFAULT = 32;

    // fixed field widths
    localparam int CH_W     = 10;
    localparam int LEVEL_W  = 8;
    localparam int DB_W     = 16;
    localparam int GAIN_W   = 8;
    localparam int MARGIN_W = 15;
    localparam int CFG_W    = 15;
    localparam int IDX_W    = 3;

    // log2 datapath
    localparam int MANT_W      = 32;
    localparam int LOG_FRAC    = 24;
    localparam int SCALE_W     = 30;
    localparam int SCALE_SHIFT = 36;
    localparam int ACC_W       = 18;
    localparam int PROD_W      = ACC_W + GAIN_W + 1;

    // 10*log10(2) in q28
    localparam logic [SCALE_W-1:0] TEN_LOG10_2_Q28 = 30'd808071242;
    // 2^23 minus 96.28 dB in q16, plus half an lsb of q8.8 for rounding
    localparam logic [21:0] DB_BIAS = 22'd2078766;
    // -100 dB in q8.8
    localparam logic signed [DB_W-1:0] ZERO_POWER_DB = -16'sd25600;

    // operation codes
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    // register map
    typedef enum logic [IDX_W-1:0] {
        REG_GAIN        = 3'd0,
        REG_MARGIN      = 3'd1,
        REG_RIGHT_FIRST = 3'd2,
        REG_RIGHT_LAST  = 3'd3,
        REG_LEFT_FIRST  = 3'd4,
        REG_LEFT_LAST   = 3'd5
    } sdq_reg_t;

    // register reset values
    localparam logic [GAIN_W-1:0]   GAIN_RESET        = 8'd10;
    localparam logic [MARGIN_W-1:0] MARGIN_RESET      = 15'd768;
    localparam logic [CH_W-1:0]     RIGHT_FIRST_RESET = 10'd103;
    localparam logic [CH_W-1:0]     RIGHT_LAST_RESET  = 10'd512;
    localparam logic [CH_W-1:0]     LEFT_FIRST_RESET  = 10'd564;
    localparam logic [CH_W-1:0]     LEFT_LAST_RESET   = 10'd973;

    // per-item data carried down the pipeline
    typedef struct packed {
        logic                   side;
        logic [CH_W-1:0]        pos;
        logic signed [DB_W-1:0] bg;
        logic                   zero;
    } sdq_tag_t;

endpackage

// ===== hw/rtl/spectrum_db_quantizer.sv =====
`timescale 1ns / 1ps

// channel   handshake               payload
// -------   ---------------------   -----------------------------------------
// input     in_valid / in_stall     operation, channel, power, background_db
// output    out_valid / out_stall   level, side, position
// config    cfg_write               cfg_index, cfg_data
//
// one transaction per clock in steady state, while out_stall stays low
// the log2 unit makes up most of the pipeline: 24 squaring stages, one 32x32 multiplier each
// reset is asynchronous and active low; it empties the pipeline and loads the
// register defaults; the background table has no reset and needs no clearing
// a stalled stage holds its data and only the stages behind it stop, so
// bubbles are squeezed out and in_stall rises only when the first stage is full

module spectrum_db_quantizer #(
    parameter int CHANNELS   = sdq_pkg::CHANNELS_DEFAULT,
    parameter int POWER_BITS = sdq_pkg::POWER_BITS_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // input transactions
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               operation,
    input  logic [sdq_pkg::CH_W-1:0]           channel,
    input  logic [POWER_BITS-1:0]              power,
    input  logic signed [sdq_pkg::DB_W-1:0]    background_db,
    // result transactions
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [sdq_pkg::LEVEL_W-1:0]        level,
    output logic                               side,
    output logic [sdq_pkg::CH_W-1:0]           position,
    // register writes
    input  logic                               cfg_write,
    input  logic [sdq_pkg::IDX_W-1:0]          cfg_index,
    input  logic [sdq_pkg::CFG_W-1:0]          cfg_data
);

    import sdq_pkg::*;

    localparam int VW     = POWER_BITS + 1;
    localparam int E_W    = $clog2(POWER_BITS + 1);
    localparam int ADDR_W = $clog2(CHANNELS);
    localparam int LOG_W  = E_W + LOG_FRAC;
    localparam int T_W    = LOG_W + SCALE_W - SCALE_SHIFT;
    localparam int SUM_W  = T_W + 1;
    localparam int NSQ    = LOG_FRAC;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [GAIN_W-1:0]   gain_reg;
    logic [MARGIN_W-1:0] margin_db_reg;
    logic [CH_W-1:0]     right_first_reg;
    logic [CH_W-1:0]     right_last_reg;
    logic [CH_W-1:0]     left_first_reg;
    logic [CH_W-1:0]     left_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg        <= GAIN_RESET;
            margin_db_reg   <= MARGIN_RESET;
            right_first_reg <= RIGHT_FIRST_RESET;
            right_last_reg  <= RIGHT_LAST_RESET;
            left_first_reg  <= LEFT_FIRST_RESET;
            left_last_reg   <= LEFT_LAST_RESET;
        end
        else if (cfg_write)
        begin
            unique case (sdq_reg_t'(cfg_index))
                REG_GAIN:        gain_reg        <= cfg_data[GAIN_W-1:0];
                REG_MARGIN:      margin_db_reg   <= cfg_data[MARGIN_W-1:0];
                REG_RIGHT_FIRST: right_first_reg <= cfg_data[CH_W-1:0];
                REG_RIGHT_LAST:  right_last_reg  <= cfg_data[CH_W-1:0];
                REG_LEFT_FIRST:  left_first_reg  <= cfg_data[CH_W-1:0];
                REG_LEFT_LAST:   left_last_reg   <= cfg_data[CH_W-1:0];
                default:         ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // input decode: window match, background table access
    // ------------------------------------------------------------------
    logic              in_accept;
    logic              is_sample;
    logic              chan_in_table;
    logic              right_hit;
    logic              left_hit;
    logic              keep;
    logic              s1_side_next;
    logic [CH_W-1:0]   s1_pos_next;
    logic [VW-1:0]     s1_v_next;
    logic              s1_zero_next;
    logic [DB_W-1:0]   ram_rdata;

    assign in_accept     = in_valid && !in_stall;
    assign is_sample     = (operation == OP_SAMPLE);
    assign chan_in_table = int'(channel) < CHANNELS;
    assign right_hit     = (right_first_reg <= channel) && (channel <= right_last_reg);
    assign left_hit      = (left_first_reg <= channel) && (channel <= left_last_reg);
    // right window wins where both match
    assign keep          = is_sample && (right_hit || left_hit);
    assign s1_side_next  = !right_hit;
    assign s1_pos_next   = right_hit ? (channel - right_first_reg) : (left_last_reg - channel);
    assign s1_v_next     = VW'(power) + VW'(1);
    assign s1_zero_next  = (power == '0);

    // loads write on acceptance, samples read on acceptance, so every sample
    // sees exactly the loads accepted before it
    sdq_ram #(
        .WIDTH (DB_W),
        .DEPTH (CHANNELS)
    ) u_background (
        .clk   (clk),
        .we    (in_accept && !is_sample && chan_in_table),
        .waddr (ADDR_W'(channel)),
        .wdata (background_db),
        .re    (in_accept && is_sample && chan_in_table),
        .raddr (ADDR_W'(channel)),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // stage 1: input register (background read data lines up with it)
    // ------------------------------------------------------------------
    logic            s1_valid_reg;
    logic            s1_side_reg;
    logic [CH_W-1:0] s1_pos_reg;
    logic [VW-1:0]   s1_v_reg;
    logic            s1_zero_reg;
    logic            s1_in_table_reg;
    logic            s1_ready;
    logic            s2_ready;

    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_stall = !s1_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_ready)
        begin
            s1_valid_reg <= in_valid && keep;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && in_valid && keep)
        begin
            s1_side_reg     <= s1_side_next;
            s1_pos_reg      <= s1_pos_next;
            s1_v_reg        <= s1_v_next;
            s1_zero_reg     <= s1_zero_next;
            s1_in_table_reg <= chan_in_table;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: leading one of power+1 gives the integer part of log2
    // ------------------------------------------------------------------
    logic [E_W-1:0] s2_e_next;
    sdq_tag_t       s2_tag_next;
    logic           s2_valid_reg;
    sdq_tag_t       s2_tag_reg;
    logic [VW-1:0]  s2_v_reg;
    logic [E_W-1:0] s2_e_reg;
    logic           s3_ready;

    always_comb
    begin
        s2_e_next = '0;
        for (int i = 0; i < VW; i++)
        begin
            if (s1_v_reg[i])
            begin
                s2_e_next = E_W'(i);
            end
        end
    end

    always_comb
    begin
        s2_tag_next.side = s1_side_reg;
        s2_tag_next.pos  = s1_pos_reg;
        // channels past the table use a zero background
        s2_tag_next.bg   = s1_in_table_reg ? signed'(ram_rdata) : '0;
        s2_tag_next.zero = s1_zero_reg;
    end

    assign s2_ready = !s2_valid_reg || s3_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_ready)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready && s1_valid_reg)
        begin
            s2_tag_reg <= s2_tag_next;
            s2_v_reg   <= s1_v_reg;
            s2_e_reg   <= s2_e_next;
        end
    end

    // ------------------------------------------------------------------
    // stage 3: normalize to a q1.31 mantissa, low bits truncated
    // ------------------------------------------------------------------
    logic [VW+MANT_W-2:0] s3_shifted;
    logic [MANT_W-1:0]    s3_x_next;
    logic                 s3_valid_reg;
    sdq_tag_t             s3_tag_reg;
    logic [E_W-1:0]       s3_e_reg;
    logic [MANT_W-1:0]    s3_x_reg;

    // bit e of power+1 lands on bit 31
    assign s3_shifted = {s2_v_reg, (MANT_W-1)'(0)} >> s2_e_reg;
    assign s3_x_next  = s3_shifted[MANT_W-1:0];

    // squaring chain, index 0 is the output of stage 3
    logic                sq_valid [NSQ+1];
    logic                sq_ready [NSQ+1];
    sdq_tag_t            sq_tag   [NSQ+1];
    logic [E_W-1:0]      sq_e     [NSQ+1];
    logic [MANT_W-1:0]   sq_x     [NSQ+1];
    logic [LOG_FRAC-1:0] sq_frac  [NSQ+1];

    assign s3_ready = !s3_valid_reg || sq_ready[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (s3_ready)
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_ready && s2_valid_reg)
        begin
            s3_tag_reg <= s2_tag_reg;
            s3_e_reg   <= s2_e_reg;
            s3_x_reg   <= s3_x_next;
        end
    end

    assign sq_valid[0] = s3_valid_reg;
    assign sq_tag[0]   = s3_tag_reg;
    assign sq_e[0]     = s3_e_reg;
    assign sq_x[0]     = s3_x_reg;
    assign sq_frac[0]  = '0;

    // ------------------------------------------------------------------
    // stages 4..27: fraction bits of log2 by repeated squaring
    // ------------------------------------------------------------------
    for (genvar g = 0; g < NSQ; g++)
    begin : g_square
        sdq_square_stage #(
            .E_W (E_W)
        ) u_square (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (sq_valid[g]),
            .up_ready (sq_ready[g]),
            .up_tag   (sq_tag[g]),
            .up_e     (sq_e[g]),
            .up_x     (sq_x[g]),
            .up_frac  (sq_frac[g]),
            .dn_valid (sq_valid[g+1]),
            .dn_ready (sq_ready[g+1]),
            .dn_tag   (sq_tag[g+1]),
            .dn_e     (sq_e[g+1]),
            .dn_x     (sq_x[g+1]),
            .dn_frac  (sq_frac[g+1])
        );
    end

    // ------------------------------------------------------------------
    // stage 28: log2 in q(e).24 times 10*log10(2) in q28, kept as q16
    // ------------------------------------------------------------------
    logic [LOG_W-1:0]         s28_log;
    logic [LOG_W+SCALE_W-1:0] s28_prod;
    logic                     s28_valid_reg;
    sdq_tag_t                 s28_tag_reg;
    logic [T_W-1:0]           s28_t_reg;
    logic                     s28_ready;
    logic                     s29_ready;

    assign s28_log  = {sq_e[NSQ], sq_frac[NSQ]};
    assign s28_prod = (LOG_W+SCALE_W)'(s28_log) * (LOG_W+SCALE_W)'(TEN_LOG10_2_Q28);

    assign s28_ready     = !s28_valid_reg || s29_ready;
    assign sq_ready[NSQ] = s28_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s28_valid_reg <= 1'b0;
        end
        else if (s28_ready)
        begin
            s28_valid_reg <= sq_valid[NSQ];
        end
    end

    always_ff @(posedge clk)
    begin
        if (s28_ready && sq_valid[NSQ])
        begin
            s28_tag_reg <= sq_tag[NSQ];
            s28_t_reg   <= s28_prod[LOG_W+SCALE_W-1:SCALE_SHIFT];
        end
    end

    // ------------------------------------------------------------------
    // stage 29: round to q8.8 dB, then dB - background + margin
    // ------------------------------------------------------------------
    logic [SUM_W-1:0]        s29_sum;
    logic signed [DB_W-1:0]  s29_db_log;
    logic signed [DB_W-1:0]  s29_db;
    logic signed [ACC_W-1:0] s29_acc_next;
    logic                    s29_valid_reg;
    logic                    s29_side_reg;
    logic [CH_W-1:0]         s29_pos_reg;
    logic signed [ACC_W-1:0] s29_acc_reg;
    logic                    s30_ready;

    // offset and round-half-up folded into one constant, then drop the 2^15 bias
    assign s29_sum    = SUM_W'(s28_t_reg) + SUM_W'(DB_BIAS);
    assign s29_db_log = DB_W'(17'(s29_sum[SUM_W-1:8]) - 17'd32768);
    // zero power reads as -100 dB
    assign s29_db     = s28_tag_reg.zero ? ZERO_POWER_DB : s29_db_log;
    assign s29_acc_next = ACC_W'(s29_db) - ACC_W'(s28_tag_reg.bg) + ACC_W'(margin_db_reg);

    assign s29_ready = !s29_valid_reg || s30_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s29_valid_reg <= 1'b0;
        end
        else if (s29_ready)
        begin
            s29_valid_reg <= s28_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s29_ready && s28_valid_reg)
        begin
            s29_side_reg <= s28_tag_reg.side;
            s29_pos_reg  <= s28_tag_reg.pos;
            s29_acc_reg  <= s29_acc_next;
        end
    end

    // ------------------------------------------------------------------
    // stage 30: scale by gain, truncate, clamp to a byte; output register
    // ------------------------------------------------------------------
    logic signed [PROD_W-1:0] s30_prod;
    logic [LEVEL_W-1:0]       level_next;
    logic                     out_valid_reg;
    logic [LEVEL_W-1:0]       level_reg;
    logic                     side_reg;
    logic [CH_W-1:0]          position_reg;

    assign s30_prod = PROD_W'(s29_acc_reg) * PROD_W'(signed'({1'b0, gain_reg}));

    always_comb
    begin
        if (s30_prod[PROD_W-1] || (s30_prod == '0))
        begin
            level_next = '0;
        end
        else if (|s30_prod[PROD_W-2:2*LEVEL_W])
        begin
            level_next = '1;
        end
        else
        begin
            level_next = s30_prod[2*LEVEL_W-1:LEVEL_W];
        end
    end

    assign s30_ready = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s30_ready)
        begin
            out_valid_reg <= s29_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s30_ready && s29_valid_reg)
        begin
            level_reg    <= level_next;
            side_reg     <= s29_side_reg;
            position_reg <= s29_pos_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign level     = level_reg;
    assign side      = side_reg;
    assign position  = position_reg;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------

    // a table load never occupies the pipeline
    a_load_not_queued: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && (operation == OP_LOAD)) |=> !s1_valid_reg)
        else $error("table load entered the pipeline");

    // a blocked first stage keeps its transaction
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s2_ready) |=> s1_valid_reg)
        else $error("first stage dropped a transaction under stall");

    // a transaction moving into the output register shows up there
    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        (s29_valid_reg && s30_ready) |=> out_valid_reg)
        else $error("result lost on the way to the output register");

endmodule

// ===== hw/rtl/sdq_ram.sv =====
`timescale 1ns / 1ps

module sdq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/sdq_square_stage.sv =====
`timescale 1ns / 1ps

module sdq_square_stage #(
    parameter int E_W = 6
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           up_valid,
    output logic                           up_ready,
    input  sdq_pkg::sdq_tag_t              up_tag,
    input  logic [E_W-1:0]                 up_e,
    input  logic [sdq_pkg::MANT_W-1:0]     up_x,
    input  logic [sdq_pkg::LOG_FRAC-1:0]   up_frac,
    output logic                           dn_valid,
    input  logic                           dn_ready,
    output sdq_pkg::sdq_tag_t              dn_tag,
    output logic [E_W-1:0]                 dn_e,
    output logic [sdq_pkg::MANT_W-1:0]     dn_x,
    output logic [sdq_pkg::LOG_FRAC-1:0]   dn_frac
);

    import sdq_pkg::*;

    logic [2*MANT_W-1:0] sq;
    logic [MANT_W:0]     sq_top;
    logic                frac_bit;
    logic [MANT_W-1:0]   x_next;
    logic [LOG_FRAC-1:0] frac_next;

    logic                valid_reg;
    sdq_tag_t            tag_reg;
    logic [E_W-1:0]      e_reg;
    logic [MANT_W-1:0]   x_reg;
    logic [LOG_FRAC-1:0] frac_reg;

    // square the q1.31 mantissa, one fraction bit falls out per stage
    assign sq        = up_x * up_x;
    assign sq_top    = sq[2*MANT_W-1:MANT_W-1];
    assign frac_bit  = sq_top[MANT_W];
    assign x_next    = frac_bit ? sq_top[MANT_W:1] : sq_top[MANT_W-1:0];
    assign frac_next = {up_frac[LOG_FRAC-2:0], frac_bit};

    assign up_ready = !valid_reg || dn_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            tag_reg  <= up_tag;
            e_reg    <= up_e;
            x_reg    <= x_next;
            frac_reg <= frac_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_tag   = tag_reg;
    assign dn_e     = e_reg;
    assign dn_x     = x_reg;
    assign dn_frac  = frac_reg;

endmodule

// ===== sim/tb_spectrum_db_quantizer.sv =====
`timescale 1ns / 1ps

// sample stream testbench for the spectrum dB byte quantizer
// a predictor mirrors the log2 / dB / excess / clamp arithmetic and the window
// mapping; results are checked in order against a queue of expected bytes

module tb_spectrum_db_quantizer;

    import sdq_pkg::*;

    // pipeline is 30 deep; the settle wait runs longer than that
    localparam int SETTLE_CYCLES   = 48;
    localparam int ITEMS_PER_PHASE = 215;
    localparam int PHASE_COUNT     = 8;
    localparam int CYCLE_LIMIT     = 250000;

    // fixed-point constants of the dB conversion
    localparam longint unsigned TWO_POW_23_Q16 = 64'd8388608;
    localparam longint unsigned OFFSET_Q16     = 64'd6309970;   // 96.28 dB
    localparam longint unsigned HALF_Q8_8_LSB  = 64'd128;

    // one result transaction
    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic               side;
        logic [CH_W-1:0]    position;
    } db_byte_t;

    // directed rows: checked by the predictor, typed in by hand, or a register write
    typedef enum logic [1:0] {
        ROW_PREDICT,
        ROW_TYPED,
        ROW_CONFIG
    } row_kind_t;

    typedef struct packed {
        row_kind_t              kind;
        logic                   op;
        logic [CH_W-1:0]        ch;
        logic [31:0]            pwr;
        logic signed [DB_W-1:0] bg;
        sdq_reg_t               idx;
        logic [CFG_W-1:0]       val;
        logic                   res_valid;
        db_byte_t               res;
    } stim_row_t;

    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    typedef struct packed {
        logic [GAIN_W-1:0]   gain;
        logic [MARGIN_W-1:0] margin;
        logic [CH_W-1:0]     right_first;
        logic [CH_W-1:0]     right_last;
        logic [CH_W-1:0]     left_first;
        logic [CH_W-1:0]     left_last;
        idle_mode_t          mode;
    } phase_cfg_t;

    // clock, reset and every block input start at known values
    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   in_valid      = 1'b0;
    logic                   operation     = OP_LOAD;
    logic [CH_W-1:0]        channel       = '0;
    logic [31:0]            power         = '0;
    logic signed [DB_W-1:0] background_db = '0;
    logic                   out_stall     = 1'b0;
    logic                   cfg_write     = 1'b0;
    logic [IDX_W-1:0]       cfg_index     = REG_GAIN;
    logic [CFG_W-1:0]       cfg_data      = '0;

    logic                   in_stall;
    logic                   out_valid;
    logic [LEVEL_W-1:0]     level;
    logic                   side;
    logic [CH_W-1:0]        position;

    // predictor copy of the registers and the background table
    logic [GAIN_W-1:0]      gain_reg;
    logic [MARGIN_W-1:0]    margin_reg;
    logic [CH_W-1:0]        right_first_reg;
    logic [CH_W-1:0]        right_last_reg;
    logic [CH_W-1:0]        left_first_reg;
    logic [CH_W-1:0]        left_last_reg;
    logic signed [DB_W-1:0] bg_table [CHANNELS_DEFAULT];
    bit                     bg_written [CHANNELS_DEFAULT];

    db_byte_t               expected_bytes [$];
    int                     fail_count    = 0;
    int                     cycle_count   = 0;
    int                     send_gap_pct  = 0;
    int                     stall_pct     = 0;

    spectrum_db_quantizer uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .operation     (operation),
        .channel       (channel),
        .power         (power),
        .background_db (background_db),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .level         (level),
        .side          (side),
        .position      (position),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #6 clk = ~clk;

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // log2 of v (v >= 2) as unsigned q6.24: normalize to q1.31, then one
    // fraction bit per squaring, truncating at every step
    function automatic longint unsigned log2_q24(input longint unsigned v);
        int unsigned       e;
        longint unsigned   x;
        longint unsigned   frac;
        e = 0;
        while (e < 63 && (v >> (e + 1)) != 0)
            e = e + 1;
        if (e >= 31)
            x = v >> (e - 31);
        else
            x = v << (31 - e);
        frac = 0;
        for (int k = 0; k < LOG_FRAC; k++)
        begin
            x    = (x * x) >> 31;
            frac = frac << 1;
            if (x >= 64'h1_0000_0000)
            begin
                frac = frac | 64'd1;
                x    = x >> 1;
            end
        end
        return (longint'(e) << LOG_FRAC) | frac;
    endfunction

    // linear power to signed q8.8 dB, rounded to nearest with ties upward
    function automatic int db_of_power(input logic [31:0] pwr);
        longint unsigned t;
        longint unsigned d16;
        if (pwr == 0)
            return int'(ZERO_POWER_DB);
        t   = (log2_q24({32'd0, pwr} + 64'd1) * longint'(TEN_LOG10_2_Q28)) >> SCALE_SHIFT;
        d16 = t + TWO_POW_23_Q16 - OFFSET_Q16 + HALF_Q8_8_LSB;
        return int'(d16 >> 8) - 32768;
    endfunction

    // window mapping and byte quantization; returns 0 when no result is due
    function automatic bit predict_byte(input logic [CH_W-1:0] ch, input logic [31:0] pwr,
                                        output db_byte_t res);
        longint excess;
        longint prod;
        longint scaled;
        res = '0;
        // right window wins where the two overlap
        if (right_first_reg <= ch && ch <= right_last_reg)
        begin
            res.side     = 1'b0;
            res.position = ch - right_first_reg;
        end
        else if (left_first_reg <= ch && ch <= left_last_reg)
        begin
            res.side     = 1'b1;
            res.position = left_last_reg - ch;
        end
        else
            return 1'b0;
        excess = longint'(db_of_power(pwr)) - longint'(bg_table[ch]) + longint'(margin_reg);
        prod   = excess * longint'(gain_reg);
        if (prod <= 0)
            res.level = '0;
        else
        begin
            scaled    = prod >>> 8;
            res.level = (scaled > 255) ? 8'hFF : scaled[7:0];
        end
        return 1'b1;
    endfunction

    // fold one accepted transaction into the predictor state
    function automatic void account_item(input logic op, input logic [CH_W-1:0] ch,
                                         input logic [31:0] pwr,
                                         input logic signed [DB_W-1:0] bg);
        db_byte_t res;
        if (op == OP_LOAD)
        begin
            bg_table[ch]   = bg;
            bg_written[ch] = 1'b1;
        end
        else if (predict_byte(ch, pwr, res))
            expected_bytes.push_back(res);
    endfunction

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------

    // random gaps first, then hold the transaction until it is taken
    task automatic send_item(input logic op, input logic [CH_W-1:0] ch,
                             input logic [31:0] pwr, input logic signed [DB_W-1:0] bg);
        while ($urandom_range(99) < send_gap_pct)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid      <= 1'b1;
        operation     <= op;
        channel       <= ch;
        power         <= pwr;
        background_db <= bg;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // wait for the pipeline to empty; loads leave no trace in the queue, so
    // also let the full latency pass
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_bytes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input sdq_reg_t idx, input logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            REG_GAIN:        gain_reg        = val[GAIN_W-1:0];
            REG_MARGIN:      margin_reg      = val[MARGIN_W-1:0];
            REG_RIGHT_FIRST: right_first_reg = val[CH_W-1:0];
            REG_RIGHT_LAST:  right_last_reg  = val[CH_W-1:0];
            REG_LEFT_FIRST:  left_first_reg  = val[CH_W-1:0];
            REG_LEFT_LAST:   left_last_reg   = val[CH_W-1:0];
            default:         ;
        endcase
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    // random transactions; samples mostly land in a window, and a sample on a
    // channel whose background was never loaded becomes that load instead
    task automatic run_random(input int count);
        int                     sel;
        int                     tmp;
        logic                   op;
        logic [CH_W-1:0]        ch;
        logic [31:0]            pwr;
        logic signed [DB_W-1:0] bg;
        for (int n = 0; n < count; n++)
        begin
            op  = ($urandom_range(99) < 20) ? OP_LOAD : OP_SAMPLE;
            sel = $urandom_range(99);
            if (sel < 38 && right_first_reg <= right_last_reg)
                ch = CH_W'($urandom_range(right_last_reg, right_first_reg));
            else if (sel < 76 && left_first_reg <= left_last_reg)
                ch = CH_W'($urandom_range(left_last_reg, left_first_reg));
            else if (sel < 88)
            begin
                // window boundaries
                case ($urandom_range(3))
                    0:       ch = right_first_reg;
                    1:       ch = right_last_reg;
                    2:       ch = left_first_reg;
                    default: ch = left_last_reg;
                endcase
            end
            else
                ch = CH_W'($urandom_range(1023, 0));
            if (op == OP_SAMPLE && !bg_written[ch])
                op = OP_LOAD;

            sel = $urandom_range(99);
            if (sel < 5)
                pwr = '0;
            else if (sel < 10)
                pwr = 32'hFFFF_FFFF;
            else if (sel < 35)
                pwr = $urandom_range(255, 1);
            else if (sel < 55)
                pwr = 32'd1 << $urandom_range(31, 0);
            else
                pwr = $urandom;

            // backgrounds near typical levels give bytes inside the clamp range
            if ($urandom_range(1) == 0)
                tmp = 0 - int'($urandom_range(9000, 0));
            else
                tmp = $urandom;
            bg = tmp[DB_W-1:0];

            send_item(op, ch, pwr, bg);
            account_item(op, ch, pwr, bg);
        end
    endtask

    function automatic stim_row_t item_row(input row_kind_t kind, input logic op,
                                           input logic [CH_W-1:0] ch, input logic [31:0] pwr,
                                           input logic signed [DB_W-1:0] bg,
                                           input logic rv, input logic [LEVEL_W-1:0] lvl,
                                           input logic sd, input logic [CH_W-1:0] pos);
        stim_row_t r;
        r              = '0;
        r.kind         = kind;
        r.op           = op;
        r.ch           = ch;
        r.pwr          = pwr;
        r.bg           = bg;
        r.res_valid    = rv;
        r.res.level    = lvl;
        r.res.side     = sd;
        r.res.position = pos;
        return r;
    endfunction

    function automatic stim_row_t cfg_row(input sdq_reg_t idx, input logic [CFG_W-1:0] val);
        stim_row_t r;
        r      = '0;
        r.kind = ROW_CONFIG;
        r.idx  = idx;
        r.val  = val;
        return r;
    endfunction

    function automatic phase_cfg_t phase(input logic [GAIN_W-1:0] g,
                                         input logic [MARGIN_W-1:0] m,
                                         input logic [CH_W-1:0] rf, input logic [CH_W-1:0] rl,
                                         input logic [CH_W-1:0] lf, input logic [CH_W-1:0] ll,
                                         input idle_mode_t mode);
        phase_cfg_t p;
        p.gain        = g;
        p.margin      = m;
        p.right_first = rf;
        p.right_last  = rl;
        p.left_first  = lf;
        p.left_last   = ll;
        p.mode        = mode;
        return p;
    endfunction

    // ------------------------------------------------------------------
    // receiver: random stall, applied at the falling edge
    // ------------------------------------------------------------------
    always @(negedge clk)
        out_stall <= ($urandom_range(99) < stall_pct);

    // ------------------------------------------------------------------
    // result checker: every taken result against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : result_check
        db_byte_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_bytes.size() == 0)
            begin
                $error("unexpected result: level %0d side %0d position %0d",
                       level, side, position);
                fail_count++;
            end
            else
            begin
                want = expected_bytes.pop_front();
                if (level !== want.level)
                begin
                    $error("level: expected %0d, got %0d", want.level, level);
                    fail_count++;
                end
                if (side !== want.side)
                begin
                    $error("side: expected %0d, got %0d", want.side, side);
                    fail_count++;
                end
                if (position !== want.position)
                begin
                    $error("position: expected %0d, got %0d", want.position, position);
                    fail_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        stim_row_t  directed [$];
        phase_cfg_t phases [PHASE_COUNT];

        // predictor starts from the register defaults, table unwritten
        gain_reg        = GAIN_RESET;
        margin_reg      = MARGIN_RESET;
        right_first_reg = RIGHT_FIRST_RESET;
        right_last_reg  = RIGHT_LAST_RESET;
        left_first_reg  = LEFT_FIRST_RESET;
        left_last_reg   = LEFT_LAST_RESET;
        foreach (bg_written[i])
        begin
            bg_written[i] = 1'b0;
            bg_table[i]   = '0;
        end

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed part, default registers: right 103..512, left 564..973
        // loads first so that every sampled channel has a background
        directed.push_back(item_row(ROW_TYPED, OP_LOAD, 10'd103, 32'd0, 16'sd0, 0, 0, 0, 0));
        directed.push_back(item_row(ROW_TYPED, OP_LOAD, 10'd512, 32'd0, 16'sd0, 0, 0, 0, 0));
        directed.push_back(item_row(ROW_TYPED, OP_LOAD, 10'd564, 32'd0, 16'sh7FFF, 0, 0, 0, 0));
        directed.push_back(item_row(ROW_TYPED, OP_LOAD, 10'd973, 32'd0, 16'sh8000, 0, 0, 0, 0));
        directed.push_back(item_row(ROW_TYPED, OP_LOAD, 10'd0, 32'd0, 16'sd0, 0, 0, 0, 0));
        directed.push_back(item_row(ROW_TYPED, OP_LOAD, 10'd1023, 32'd0, 16'sd0, 0, 0, 0, 0));
        // zero power is -100 dB: far below the margin, byte 0
        directed.push_back(item_row(ROW_TYPED, OP_SAMPLE, 10'd103, 32'd0, 16'sd0,
                                    1, 8'd0, 1'b0, 10'd0));
        directed.push_back(item_row(ROW_TYPED, OP_SAMPLE, 10'd512, 32'd0, 16'sd0,
                                    1, 8'd0, 1'b0, 10'd409));
        // most negative background drives the byte into the upper clamp
        directed.push_back(item_row(ROW_TYPED, OP_SAMPLE, 10'd973, 32'd0, 16'sd0,
                                    1, 8'd255, 1'b1, 10'd0));
        // full-scale power against the most positive background
        directed.push_back(item_row(ROW_TYPED, OP_SAMPLE, 10'd564, 32'hFFFF_FFFF, 16'sd0,
                                    1, 8'd0, 1'b1, 10'd409));
        // outside both windows
        directed.push_back(item_row(ROW_TYPED, OP_SAMPLE, 10'd0, 32'hFFFF_FFFF, 16'sd0,
                                    0, 0, 0, 0));
        directed.push_back(item_row(ROW_TYPED, OP_SAMPLE, 10'd1023, 32'd1, 16'sd0, 0, 0, 0, 0));
        // mid-range levels
        directed.push_back(item_row(ROW_PREDICT, OP_LOAD, 10'd300, 32'd0, -16'sd5000, 0, 0, 0, 0));
        directed.push_back(item_row(ROW_PREDICT, OP_SAMPLE, 10'd300, 32'd1, 16'sd0, 0, 0, 0, 0));
        directed.push_back(item_row(ROW_PREDICT, OP_SAMPLE, 10'd300, 32'd123456, 16'sd0,
                                    0, 0, 0, 0));
        directed.push_back(item_row(ROW_PREDICT, OP_SAMPLE, 10'd300, 32'h8000_0000, 16'sd0,
                                    0, 0, 0, 0));
        directed.push_back(item_row(ROW_PREDICT, OP_LOAD, 10'd700, 32'd0, -16'sd2000, 0, 0, 0, 0));
        directed.push_back(item_row(ROW_PREDICT, OP_SAMPLE, 10'd700, 32'hDEAD_BEEF, 16'sd0,
                                    0, 0, 0, 0));
        // overlapping windows: the right window takes the channel
        directed.push_back(cfg_row(REG_RIGHT_LAST, 15'd700));
        directed.push_back(item_row(ROW_PREDICT, OP_SAMPLE, 10'd700, 32'h5555_5555, 16'sd0,
                                    0, 0, 0, 0));
        // empty left window: first beyond last
        directed.push_back(cfg_row(REG_LEFT_FIRST, 15'd1000));
        directed.push_back(item_row(ROW_TYPED, OP_SAMPLE, 10'd973, 32'd0, 16'sd0, 0, 0, 0, 0));
        // gain and margin extremes
        directed.push_back(cfg_row(REG_GAIN, 15'd255));
        directed.push_back(cfg_row(REG_MARGIN, 15'h7FFF));
        directed.push_back(item_row(ROW_TYPED, OP_SAMPLE, 10'd103, 32'hFFFF_FFFF, 16'sd0,
                                    1, 8'd255, 1'b0, 10'd0));
        directed.push_back(cfg_row(REG_GAIN, 15'd0));
        directed.push_back(item_row(ROW_TYPED, OP_SAMPLE, 10'd103, 32'hFFFF_FFFF, 16'sd0,
                                    1, 8'd0, 1'b0, 10'd0));

        foreach (directed[i])
        begin
            if (directed[i].kind == ROW_CONFIG)
            begin
                settle();
                write_reg(directed[i].idx, directed[i].val);
            end
            else
            begin
                send_item(directed[i].op, directed[i].ch, directed[i].pwr, directed[i].bg);
                if (directed[i].kind == ROW_PREDICT || directed[i].op == OP_LOAD)
                    account_item(directed[i].op, directed[i].ch, directed[i].pwr,
                                 directed[i].bg);
                else if (directed[i].res_valid)
                    expected_bytes.push_back(directed[i].res);
            end
        end

        // random phases: each rewrites every register, then runs under one idling mode
        phases[0] = phase(8'd10,  15'd768,   10'd103,  10'd512,  10'd564,  10'd973, IDLE_NONE);
        phases[1] = phase(8'd255, 15'd0,     10'd0,    10'd1023, 10'd0,    10'd1023, IDLE_SENDER);
        phases[2] = phase(8'd0,   15'h7FFF,  10'd0,    10'd511,  10'd512,  10'd1023, IDLE_RECEIVER);
        phases[3] = phase(8'd1,   15'h7FFF,  10'd1023, 10'd1023, 10'd0,    10'd0,    IDLE_BOTH);
        phases[4] = phase(8'd37,  15'd1200,  10'd700,  10'd100,  10'd0,    10'd1023, IDLE_NONE);
        phases[5] = phase(8'd200, 15'd256,   10'd300,  10'd800,  10'd400,  10'd900,  IDLE_SENDER);
        phases[6] = phase(8'd16,  15'd5000,  10'd0,    10'd1023, 10'd1023, 10'd0,    IDLE_RECEIVER);
        phases[7] = phase(8'd128, 15'd768,   10'd200,  10'd400,  10'd600,  10'd1000, IDLE_BOTH);

        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            settle();
            write_reg(REG_GAIN,        CFG_W'(phases[p].gain));
            write_reg(REG_MARGIN,      phases[p].margin);
            write_reg(REG_RIGHT_FIRST, CFG_W'(phases[p].right_first));
            write_reg(REG_RIGHT_LAST,  CFG_W'(phases[p].right_last));
            write_reg(REG_LEFT_FIRST,  CFG_W'(phases[p].left_first));
            write_reg(REG_LEFT_LAST,   CFG_W'(phases[p].left_last));
            case (phases[p].mode)
                IDLE_SENDER:   begin send_gap_pct = 69; stall_pct = 0;  end
                IDLE_RECEIVER: begin send_gap_pct = 0;  stall_pct = 69; end
                IDLE_BOTH:     begin send_gap_pct = 31; stall_pct = 31; end
                default:       begin send_gap_pct = 0;  stall_pct = 0;  end
            endcase
            run_random(ITEMS_PER_PHASE);
        end

        // drain, then a quiet stretch to catch stray results
        settle();
        if (fail_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
